// ===== sv/frg_pkg.sv =====
// shared types and codes for the fraction reduction unit
package frg_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_SCALE,
    S_DIV_NUM,
    S_NEXT_DEN,
    S_DIV_DEN,
    S_FINISH
  } state_t;

  // datapath operations issued by the sequencer
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_GCD,
    OP_SCALE,
    OP_NUM_INIT,
    OP_DIV_STEP,
    OP_DEN_INIT,
    OP_OUTPUT
  } op_t;

  // result status codes
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_REDUCED     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_IRREDUCIBLE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED    = 2'd2;

  // sequencer to datapath
  typedef struct packed {
    op_t op;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_zero;
    logic a_zero;
    logic k_zero;
    logic cnt_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== sv/frg_sub.sv =====
// shared subtractor with borrow, used by the gcd loop and the divider
module frg_sub #(
  parameter int unsigned W = 32
) (
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  output logic [W-1:0] diff,
  output logic         borrow
);

  logic [W:0] full;

  // one wide subtract, borrow taken from the extra top bit
  assign full   = {1'b0, x} - {1'b0, y};
  assign diff   = full[W-1:0];
  assign borrow = full[W];

endmodule

// ===== sv/frg_ctrl.sv =====
// sequencer for the gcd, scale and two division phases
module frg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  frg_pkg::sts_t sts,
  output frg_pkg::ctl_t ctl
);

  frg_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frg_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_zero ? frg_pkg::S_FINISH : frg_pkg::S_GCD;
        end
      end
      frg_pkg::S_GCD: begin
        if (sts.a_zero) state_nxt = frg_pkg::S_SCALE;
      end
      frg_pkg::S_SCALE: begin
        if (sts.k_zero) state_nxt = frg_pkg::S_DIV_NUM;
      end
      frg_pkg::S_DIV_NUM: begin
        if (sts.cnt_last) state_nxt = frg_pkg::S_NEXT_DEN;
      end
      frg_pkg::S_NEXT_DEN: begin
        state_nxt = frg_pkg::S_DIV_DEN;
      end
      frg_pkg::S_DIV_DEN: begin
        if (sts.cnt_last) state_nxt = frg_pkg::S_FINISH;
      end
      frg_pkg::S_FINISH: begin
        if (!sts.out_busy) state_nxt = frg_pkg::S_IDLE;
      end
      default: begin
        state_nxt = frg_pkg::S_IDLE;
      end
    endcase
  end

  // operation and handshake outputs
  always_comb begin
    in_ready = 1'b0;
    ctl.op   = frg_pkg::OP_NONE;
    case (state_r)
      frg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.op = frg_pkg::OP_LOAD;
      end
      frg_pkg::S_GCD: begin
        ctl.op = frg_pkg::OP_GCD;
      end
      frg_pkg::S_SCALE: begin
        ctl.op = sts.k_zero ? frg_pkg::OP_NUM_INIT : frg_pkg::OP_SCALE;
      end
      frg_pkg::S_DIV_NUM: begin
        ctl.op = frg_pkg::OP_DIV_STEP;
      end
      frg_pkg::S_NEXT_DEN: begin
        ctl.op = frg_pkg::OP_DEN_INIT;
      end
      frg_pkg::S_DIV_DEN: begin
        ctl.op = frg_pkg::OP_DIV_STEP;
      end
      frg_pkg::S_FINISH: begin
        if (!sts.out_busy) ctl.op = frg_pkg::OP_OUTPUT;
      end
      default: begin
        ctl.op = frg_pkg::OP_NONE;
      end
    endcase
  end

  // a finished result leaves for the output register once it is free
  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frg_pkg::S_FINISH && !sts.out_busy) |=> (state_r == frg_pkg::S_IDLE))
    else $error("finish did not return to idle");

  // a zero operand skips the gcd and division phases
  a_zero_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frg_pkg::S_IDLE && in_valid && sts.in_zero)
      |=> (state_r == frg_pkg::S_FINISH))
    else $error("zero operand entered the gcd loop");

  // ready only while no transaction is in progress
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |=> !in_ready)
    else $error("second transaction accepted while busy");

endmodule

// ===== sv/frg_dp.sv =====
// datapath: binary gcd, scale by common power of two, restoring divisions
module frg_dp #(
  parameter int unsigned W = 31
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  frg_pkg::ctl_t                  ctl,
  output frg_pkg::sts_t                  sts,
  input  logic [W-1:0]                   in_numerator,
  input  logic [W-1:0]                   in_denominator,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [W-1:0]                   out_reduced_numerator,
  output logic [W-1:0]                   out_reduced_denominator,
  output logic [W-1:0]                   out_common_divisor,
  output logic [frg_pkg::STATUS_W-1:0]   out_status
);

  localparam int unsigned KW = $clog2(W);
  localparam int unsigned CW = $clog2(W);

  // a: gcd operand, then division remainder; b: gcd operand, then divisor
  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [W-1:0]  quo_r, quo_nxt, rn_r, rn_nxt;
  logic [W-1:0]  num_r, den_r;
  logic          rej_r;
  logic [KW-1:0] k_r, k_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  logic [W-1:0]  out_rn_r, out_rd_r, out_g_r;
  logic [frg_pkg::STATUS_W-1:0] out_st_r;

  logic [W:0]    sub_x, sub_y, sub_diff;
  logic          sub_borrow;

  // shared subtractor operands
  assign sub_x = (ctl.op == frg_pkg::OP_DIV_STEP) ? {a_r, quo_r[W-1]} : {1'b0, a_r};
  assign sub_y = {1'b0, b_r};

  frg_sub #(.W(W + 1)) u_sub (
    .x      (sub_x),
    .y      (sub_y),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // status back to the sequencer
  assign sts.in_zero  = (in_numerator == '0) || (in_denominator == '0);
  assign sts.a_zero   = (a_r == '0);
  assign sts.k_zero   = (k_r == '0);
  assign sts.cnt_last = (cnt_r == CW'(W - 1));
  assign sts.out_busy = out_valid_r && !out_ready;

  // next values of the working registers
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    k_nxt   = k_r;
    quo_nxt = quo_r;
    rn_nxt  = rn_r;
    cnt_nxt = cnt_r;
    case (ctl.op)
      frg_pkg::OP_LOAD: begin
        a_nxt = in_numerator;
        b_nxt = in_denominator;
        k_nxt = '0;
      end
      frg_pkg::OP_GCD: begin
        if (a_r != '0) begin
          if (!a_r[0] && !b_r[0]) begin
            a_nxt = {1'b0, a_r[W-1:1]};
            b_nxt = {1'b0, b_r[W-1:1]};
            k_nxt = k_r + KW'(1);
          end else if (!a_r[0]) begin
            a_nxt = {1'b0, a_r[W-1:1]};
          end else if (!b_r[0]) begin
            b_nxt = {1'b0, b_r[W-1:1]};
          end else if (sub_borrow) begin
            // both odd and a below b: swap so the next step subtracts
            a_nxt = b_r;
            b_nxt = a_r;
          end else begin
            a_nxt = sub_diff[W-1:0];
          end
        end
      end
      frg_pkg::OP_SCALE: begin
        b_nxt = {b_r[W-2:0], 1'b0};
        k_nxt = k_r - KW'(1);
      end
      frg_pkg::OP_NUM_INIT: begin
        a_nxt   = '0;
        quo_nxt = num_r;
        cnt_nxt = '0;
      end
      frg_pkg::OP_DIV_STEP: begin
        a_nxt   = sub_borrow ? sub_x[W-1:0] : sub_diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], ~sub_borrow};
        cnt_nxt = cnt_r + CW'(1);
      end
      frg_pkg::OP_DEN_INIT: begin
        rn_nxt  = quo_r;
        a_nxt   = '0;
        quo_nxt = den_r;
        cnt_nxt = '0;
      end
      default: begin
        a_nxt = a_r;
      end
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    quo_r <= quo_nxt;
    rn_r  <= rn_nxt;
    cnt_r <= cnt_nxt;
    if (ctl.op == frg_pkg::OP_LOAD) begin
      num_r <= in_numerator;
      den_r <= in_denominator;
      rej_r <= sts.in_zero;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (ctl.op == frg_pkg::OP_OUTPUT) begin
      if (rej_r) begin
        out_rn_r <= '0;
        out_rd_r <= '0;
        out_g_r  <= '0;
        out_st_r <= frg_pkg::STATUS_REJECTED;
      end else begin
        out_rn_r <= rn_r;
        out_rd_r <= quo_r;
        out_g_r  <= b_r;
        out_st_r <= (b_r == W'(1)) ? frg_pkg::STATUS_IRREDUCIBLE
                                   : frg_pkg::STATUS_REDUCED;
      end
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.op == frg_pkg::OP_OUTPUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_reduced_numerator   = out_rn_r;
  assign out_reduced_denominator = out_rd_r;
  assign out_common_divisor      = out_g_r;
  assign out_status              = out_st_r;

  // the remainder always stays below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == frg_pkg::OP_DIV_STEP) |-> (a_r < b_r))
    else $error("division remainder not below divisor");

  // the gcd loop never runs with a zero second operand
  a_b_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == frg_pkg::OP_GCD) |-> (b_r != '0))
    else $error("gcd operand b became zero");

  // loading a result always raises valid
  a_output_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == frg_pkg::OP_OUTPUT) |=> out_valid_r)
    else $error("result loaded without valid");

endmodule

// ===== sv/fraction_reduce_gcd_unit.sv =====
// top level: fraction reduction by gcd on one shared subtractor
//
//   channel  ports                                               direction
//   in       in_valid, in_ready, in_numerator, in_denominator     into block
//   out      out_valid, out_ready, out_reduced_numerator,         out of block
//            out_reduced_denominator, out_common_divisor, out_status
//
// one transaction runs, from acceptance until the result is loaded: n binary gcd
// steps (one per halving, subtraction or swap), k doublings for the shared power
// of two and two W-step restoring divisions; the gcd subtractions and the
// division steps share one subtractor
// a zero operand skips the gcd and division phases and is reported as rejected
// reset clears the sequencer and the output valid flag only
// in_ready is high only when the sequencer is idle; a finished result waits
// in the output register, and a new transaction may be taken meanwhile
module fraction_reduce_gcd_unit #(
  parameter int unsigned OPERAND_WIDTH = 31
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [OPERAND_WIDTH-1:0]             in_numerator,
  input  logic [OPERAND_WIDTH-1:0]             in_denominator,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [OPERAND_WIDTH-1:0]             out_reduced_numerator,
  output logic [OPERAND_WIDTH-1:0]             out_reduced_denominator,
  output logic [OPERAND_WIDTH-1:0]             out_common_divisor,
  output logic [frg_pkg::STATUS_W-1:0]         out_status
);

  frg_pkg::ctl_t ctl;
  frg_pkg::sts_t sts;

  // sequencer
  frg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath
  frg_dp #(.W(OPERAND_WIDTH)) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .ctl                     (ctl),
    .sts                     (sts),
    .in_numerator            (in_numerator),
    .in_denominator          (in_denominator),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_reduced_numerator   (out_reduced_numerator),
    .out_reduced_denominator (out_reduced_denominator),
    .out_common_divisor      (out_common_divisor),
    .out_status              (out_status)
  );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the gcd fraction reduction unit
module testbench;

  localparam int unsigned OPERAND_WIDTH   = 31;
  localparam int          RANDOM_ITEMS    = 1200;
  localparam int          QUIET_ITEMS     = 150;
  localparam int          LONG_HOLD_AT    = 300;
  localparam int          LONG_HOLD_CYCLES = 600;
  localparam int          PAUSE_AT        = 650;
  localparam int          DRAIN_CYCLES    = 250;
  localparam int          CYCLE_LIMIT     = 2000000;

  localparam logic [OPERAND_WIDTH-1:0] OP_MAX = '1;
  localparam logic [OPERAND_WIDTH-1:0] OP_TOP = {1'b1, {(OPERAND_WIDTH - 1){1'b0}}};

  // one reduced fraction as it leaves the block
  typedef struct packed {
    logic [OPERAND_WIDTH-1:0]     reduced_num;
    logic [OPERAND_WIDTH-1:0]     reduced_den;
    logic [OPERAND_WIDTH-1:0]     divisor;
    logic [frg_pkg::STATUS_W-1:0] status;
  } fraction_t;

  // one row of the directed stimulus; known rows carry their answer
  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] num;
    logic [OPERAND_WIDTH-1:0] den;
    logic                     known;
    fraction_t                answer;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [OPERAND_WIDTH-1:0]     in_numerator;
  logic [OPERAND_WIDTH-1:0]     in_denominator;
  logic                         out_valid;
  logic                         out_ready;
  logic [OPERAND_WIDTH-1:0]     out_reduced_numerator;
  logic [OPERAND_WIDTH-1:0]     out_reduced_denominator;
  logic [OPERAND_WIDTH-1:0]     out_common_divisor;
  logic [frg_pkg::STATUS_W-1:0] out_status;

  fraction_t pending_fractions[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        quiet_phase = 1'b0;
  bit        long_hold_due = 1'b0;

  // directed rows: extremes, zero operands, irreducible and reducible pairs
  stim_row_t directed_rows [20] = '{
    '{31'd0, 31'd0, 1'b1, '{31'd0, 31'd0, 31'd0, frg_pkg::STATUS_REJECTED}},
    '{31'd0, OP_MAX, 1'b1, '{31'd0, 31'd0, 31'd0, frg_pkg::STATUS_REJECTED}},
    '{OP_MAX, 31'd0, 1'b1, '{31'd0, 31'd0, 31'd0, frg_pkg::STATUS_REJECTED}},
    '{31'd0, 31'd1, 1'b1, '{31'd0, 31'd0, 31'd0, frg_pkg::STATUS_REJECTED}},
    '{31'd1, 31'd1, 1'b1, '{31'd1, 31'd1, 31'd1, frg_pkg::STATUS_IRREDUCIBLE}},
    '{OP_MAX, OP_MAX, 1'b1, '{31'd1, 31'd1, OP_MAX, frg_pkg::STATUS_REDUCED}},
    '{OP_MAX, 31'd1, 1'b1, '{OP_MAX, 31'd1, 31'd1, frg_pkg::STATUS_IRREDUCIBLE}},
    '{31'd1, OP_MAX, 1'b1, '{31'd1, OP_MAX, 31'd1, frg_pkg::STATUS_IRREDUCIBLE}},
    '{OP_MAX, OP_MAX - 31'd1, 1'b1,
      '{OP_MAX, OP_MAX - 31'd1, 31'd1, frg_pkg::STATUS_IRREDUCIBLE}},
    '{OP_TOP, OP_TOP, 1'b1, '{31'd1, 31'd1, OP_TOP, frg_pkg::STATUS_REDUCED}},
    '{OP_TOP, 31'd2, 1'b1, '{OP_TOP >> 1, 31'd1, 31'd2, frg_pkg::STATUS_REDUCED}},
    '{31'd6, 31'd4, 1'b1, '{31'd3, 31'd2, 31'd2, frg_pkg::STATUS_REDUCED}},
    '{31'd12345678, 31'd87654321, 1'b0, '0},
    '{OP_TOP, 31'd1162261467, 1'b0, '0},
    '{31'h55555555, 31'h2AAAAAAA, 1'b0, '0},
    '{31'd1836311903, 31'd1134903170, 1'b0, '0},
    '{31'd2000000014, 31'd1000000007, 1'b0, '0},
    '{31'h7FFF0000, 31'h0000FFFF, 1'b0, '0},
    '{31'd3, OP_MAX - 31'd1, 1'b0, '0},
    '{31'd3072, 31'd5120, 1'b0, '0}
  };

  fraction_reduce_gcd_unit #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_numerator           (in_numerator),
    .in_denominator         (in_denominator),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_reduced_numerator  (out_reduced_numerator),
    .out_reduced_denominator(out_reduced_denominator),
    .out_common_divisor     (out_common_divisor),
    .out_status             (out_status)
  );

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lowest terms by euclid, zero operands rejected
  function automatic fraction_t reduce_fraction(input logic [OPERAND_WIDTH-1:0] num,
                                                input logic [OPERAND_WIDTH-1:0] den);
    fraction_t                res;
    logic [OPERAND_WIDTH-1:0] a;
    logic [OPERAND_WIDTH-1:0] b;
    logic [OPERAND_WIDTH-1:0] r;
    res = '0;
    if (num == '0 || den == '0) begin
      res.status = frg_pkg::STATUS_REJECTED;
      return res;
    end
    a = num;
    b = den;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    res.reduced_num = num / a;
    res.reduced_den = den / a;
    res.divisor     = a;
    res.status      = (a > 1) ? frg_pkg::STATUS_REDUCED : frg_pkg::STATUS_IRREDUCIBLE;
    return res;
  endfunction

  function automatic logic [OPERAND_WIDTH-1:0] random_operand();
    logic [31:0] r;
    r = $urandom;
    return r[OPERAND_WIDTH-1:0];
  endfunction

  // random operand pairs, weighted towards zero operands, shared factors and trailing zeros
  task automatic make_operands(output logic [OPERAND_WIDTH-1:0] num,
                               output logic [OPERAND_WIDTH-1:0] den);
    int                kind;
    int                gb;
    int                ab;
    longint unsigned   g;
    longint unsigned   a;
    longint unsigned   b;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      // zero operand on one or both sides
      num = random_operand();
      den = random_operand();
      case ($urandom_range(0, 2))
        0: num = '0;
        1: den = '0;
        default: begin
          num = '0;
          den = '0;
        end
      endcase
    end else if (kind < 40) begin
      // common factor of random size times two random cofactors
      gb = $urandom_range(1, 20);
      g  = longint'($urandom) & ((64'd1 << gb) - 1);
      if (g == 0) g = 1;
      ab = $urandom_range(1, OPERAND_WIDTH - gb);
      a  = longint'($urandom) & ((64'd1 << ab) - 1);
      if (a == 0) a = 1;
      ab = $urandom_range(1, OPERAND_WIDTH - gb);
      b  = longint'($urandom) & ((64'd1 << ab) - 1);
      if (b == 0) b = 1;
      num = OPERAND_WIDTH'(g * a);
      den = OPERAND_WIDTH'(b * g);
    end else if (kind < 55) begin
      // many trailing zeros
      num = random_operand() << $urandom_range(0, OPERAND_WIDTH - 1);
      den = random_operand() << $urandom_range(0, OPERAND_WIDTH - 1);
    end else if (kind < 70) begin
      num = OPERAND_WIDTH'($urandom_range(1, 1000));
      den = OPERAND_WIDTH'($urandom_range(1, 1000));
    end else begin
      num = random_operand();
      den = random_operand();
    end
  endtask

  // offer one transaction, record its expectation on acceptance
  task automatic send_fraction(input logic [OPERAND_WIDTH-1:0] num,
                               input logic [OPERAND_WIDTH-1:0] den,
                               input fraction_t                answer);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_numerator   <= num;
    in_denominator <= den;
    do @(posedge clk); while (!in_ready);
    pending_fractions.push_back(answer);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [OPERAND_WIDTH-1:0] got,
                             input logic [OPERAND_WIDTH-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // result checker
  always @(posedge clk) begin
    fraction_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_fractions.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_fractions.pop_front();
        check_field("reduced_numerator", out_reduced_numerator, want.reduced_num);
        check_field("reduced_denominator", out_reduced_denominator, want.reduced_den);
        check_field("common_divisor", out_common_divisor, want.divisor);
        check_field("status", OPERAND_WIDTH'(out_status), OPERAND_WIDTH'(want.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure: random bursts, one long hold
  initial begin : result_sink
    int span;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_ready <= 1'b0;
        span = 1;
        while (span < LONG_HOLD_CYCLES) begin
          @(negedge clk);
          span++;
        end
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        span = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (span - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        if (!quiet_phase) repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [OPERAND_WIDTH-1:0] num;
    logic [OPERAND_WIDTH-1:0] den;
    fraction_t                answer;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_numerator   = '0;
    in_denominator = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      answer = directed_rows[i].known ? directed_rows[i].answer :
               reduce_fraction(directed_rows[i].num, directed_rows[i].den);
      send_fraction(directed_rows[i].num, directed_rows[i].den, answer);
    end

    // random part
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == LONG_HOLD_AT) long_hold_due = 1'b1;
      if (i == PAUSE_AT) begin
        // sender holds off until the block has emptied
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_fractions.size() != 0) @(posedge clk);
      end
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
      make_operands(num, den);
      send_fraction(num, den, reduce_fraction(num, den));
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_fractions.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
